// ----- hw/rtl/mtlb_pkg.sv -----
`timescale 1ns / 1ps
// types, constants and codes shared by the tlb address translator
package mtlb_pkg;

  localparam int TLB_SLOTS_DEF = 48;
  localparam int VA_W          = 32;
  localparam int IDX_W         = 6;
  localparam int PAGE_OFF_W    = 12;
  localparam int MASK_W        = 12;
  localparam int ASID_W        = 8;
  localparam int PFN_W         = 20;
  localparam int VPN2_W        = 19;
  localparam int FLAGS_W       = 2;
  localparam int KSU_W         = 2;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;
  localparam int SPAD_OFF_W    = 14;

  localparam logic [PAGE_OFF_W-1:0] PAGE_OFF_MASK = 12'hFFF;

  localparam logic [KSU_W-1:0] KSU_KERNEL   = 2'd0;
  localparam logic [KSU_W-1:0] KSU_SUPER    = 2'd1;
  localparam logic [KSU_W-1:0] KSU_USER     = 2'd2;
  localparam logic [KSU_W-1:0] KSU_RESERVED = 2'd3;

  localparam logic [2:0] SEG_KSEG0  = 3'b100;
  localparam logic [2:0] SEG_KSEG1  = 3'b101;
  localparam logic [2:0] SEG_KSSEG  = 3'b110;

  localparam int FLAG_VALID = 0;
  localparam int FLAG_DIRTY = 1;

  typedef enum logic [2:0] {
    EXC_NONE          = 3'd0,
    EXC_ADDR_LOAD     = 3'd1,
    EXC_ADDR_STORE    = 3'd2,
    EXC_REFILL_LOAD   = 3'd3,
    EXC_REFILL_STORE  = 3'd4,
    EXC_INVALID_LOAD  = 3'd5,
    EXC_INVALID_STORE = 3'd6,
    EXC_MODIFIED      = 3'd7
  } exc_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE_KSU        = 3'd0,
    CFG_EXCEPTION_LEVEL = 3'd1,
    CFG_ERROR_LEVEL     = 3'd2,
    CFG_CURRENT_ASID    = 3'd3,
    CFG_SCRATCHPAD_BASE = 3'd4
  } cfg_idx_t;

  typedef enum logic {
    CMD_TRANSLATE = 1'b0,
    CMD_WRITE     = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [KSU_W-1:0]  ksu;
    logic              exl;
    logic              erl;
    logic [ASID_W-1:0] asid;
    logic [VA_W-1:0]   spad_base;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    ksu:       KSU_KERNEL,
    exl:       1'b0,
    erl:       1'b1,
    asid:      '0,
    spad_base: 32'h7000_0000
  };

  typedef struct packed {
    logic                cmd;
    logic [VA_W-1:0]     vaddr;
    logic                is_write;
    logic [IDX_W-1:0]    entry_index;
    logic [MASK_W-1:0]   entry_mask;
    logic [ASID_W-1:0]   entry_asid;
    logic                entry_global;
    logic                entry_scratchpad;
    logic [PFN_W-1:0]    entry_pfn_even;
    logic [PFN_W-1:0]    entry_pfn_odd;
    logic [FLAGS_W-1:0]  entry_flags_even;
    logic [FLAGS_W-1:0]  entry_flags_odd;
  } in_item_t;

  typedef struct packed {
    logic [VPN2_W-1:0]  vpn2;
    logic [ASID_W-1:0]  asid;
    logic               glob;
    logic               spad;
    logic [MASK_W-1:0]  mask;
    logic [PFN_W-1:0]   pfn_even;
    logic [FLAGS_W-1:0] flags_even;
    logic [PFN_W-1:0]   pfn_odd;
    logic [FLAGS_W-1:0] flags_odd;
  } slot_t;

  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] index;
    slot_t            slot;
  } lookup_t;

  typedef struct packed {
    logic [VA_W-1:0]  paddr;
    exc_t             exc_code;
    logic [IDX_W-1:0] hit_index;
  } result_t;

endpackage

// ----- hw/rtl/mtlb_ifs.sv -----
`timescale 1ns / 1ps
// handshake channel interfaces for request, result and register write transactions
interface mtlb_in_if import mtlb_pkg::*;;
  logic                valid;
  logic                ready;
  logic                cmd;
  logic [VA_W-1:0]     vaddr;
  logic                is_write;
  logic [IDX_W-1:0]    entry_index;
  logic [MASK_W-1:0]   entry_mask;
  logic [ASID_W-1:0]   entry_asid;
  logic                entry_global;
  logic                entry_scratchpad;
  logic [PFN_W-1:0]    entry_pfn_even;
  logic [PFN_W-1:0]    entry_pfn_odd;
  logic [FLAGS_W-1:0]  entry_flags_even;
  logic [FLAGS_W-1:0]  entry_flags_odd;

  modport source (
    output valid, cmd, vaddr, is_write, entry_index, entry_mask, entry_asid,
           entry_global, entry_scratchpad, entry_pfn_even, entry_pfn_odd,
           entry_flags_even, entry_flags_odd,
    input  ready
  );
  modport sink (
    input  valid, cmd, vaddr, is_write, entry_index, entry_mask, entry_asid,
           entry_global, entry_scratchpad, entry_pfn_even, entry_pfn_odd,
           entry_flags_even, entry_flags_odd,
    output ready
  );
endinterface

interface mtlb_out_if import mtlb_pkg::*;;
  logic             valid;
  logic             ready;
  logic [VA_W-1:0]  paddr;
  logic [2:0]       exc_code;
  logic [IDX_W-1:0] hit_index;

  modport source (output valid, paddr, exc_code, hit_index, input ready);
  modport sink (input valid, paddr, exc_code, hit_index, output ready);
endinterface

interface mtlb_cfg_if import mtlb_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hw/rtl/mtlb_slots.sv -----
`timescale 1ns / 1ps
// tlb slot store with parallel vpn2 match and lowest-index hit select
module mtlb_slots
  import mtlb_pkg::*;
#(
  parameter int TLB_SLOTS = TLB_SLOTS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     wr_en,
  input  in_item_t item,
  output lookup_t  lookup
);

  localparam int SLOT_BITS = $bits(slot_t);

  logic [TLB_SLOTS-1:0] used_r;
  slot_t                slot_r [TLB_SLOTS];
  slot_t                wr_slot;
  logic [VPN2_W-1:0]    vpn2;
  logic [TLB_SLOTS-1:0] match;
  logic [TLB_SLOTS-1:0] first;
  logic [SLOT_BITS-1:0] sel_bits;
  logic [IDX_W-1:0]     sel_idx;

  assign wr_slot = '{
    vpn2:       item.vaddr[VA_W-1 -: VPN2_W],
    asid:       item.entry_asid,
    glob:       item.entry_global,
    spad:       item.entry_scratchpad,
    mask:       item.entry_mask,
    pfn_even:   item.entry_pfn_even,
    flags_even: item.entry_flags_even,
    pfn_odd:    item.entry_pfn_odd,
    flags_odd:  item.entry_flags_odd
  };

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else begin
      for (int i = 0; i < TLB_SLOTS; i++) begin
        if (wr_en && item.entry_index == IDX_W'(i)) begin
          used_r[i] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TLB_SLOTS; i++) begin
      if (wr_en && item.entry_index == IDX_W'(i)) begin
        slot_r[i] <= wr_slot;
      end
    end
  end

  assign vpn2 = item.vaddr[VA_W-1 -: VPN2_W];

  // masked bits of the page mask are ignored in the compare
  always_comb begin
    for (int i = 0; i < TLB_SLOTS; i++) begin
      match[i] = used_r[i] &&
                 (((slot_r[i].vpn2 ^ vpn2) & {{(VPN2_W-MASK_W){1'b1}}, ~slot_r[i].mask}) == '0);
    end
  end

  assign first = match & (~match + TLB_SLOTS'(1));

  always_comb begin
    sel_bits = '0;
    sel_idx  = '0;
    for (int i = 0; i < TLB_SLOTS; i++) begin
      sel_bits = sel_bits | (slot_r[i] & {SLOT_BITS{first[i]}});
      if (first[i]) begin
        sel_idx = sel_idx | IDX_W'(i);
      end
    end
  end

  assign lookup = '{hit: |match, index: sel_idx, slot: slot_t'(sel_bits)};

endmodule

// ----- hw/rtl/mtlb_xlate.sv -----
`timescale 1ns / 1ps
// segment decode, permission checks and physical address forming
module mtlb_xlate
  import mtlb_pkg::*;
(
  input  cfg_t     cfg,
  input  in_item_t item,
  input  lookup_t  lookup,
  output result_t  res
);

  logic             kernel;
  logic [2:0]       seg;
  logic             use_tlb;
  logic [VA_W-1:0]  pmask;
  logic             odd;
  logic [PFN_W-1:0] pfn;
  logic [FLAGS_W-1:0] flags;
  logic             st;
  result_t          tlb_res;

  assign st     = item.is_write;
  assign seg    = item.vaddr[VA_W-1 -: 3];
  assign kernel = (cfg.ksu == KSU_KERNEL) || cfg.exl || cfg.erl;

  assign pmask = {{(VA_W-MASK_W-PAGE_OFF_W){1'b0}}, lookup.slot.mask, PAGE_OFF_MASK};
  assign odd   = |(item.vaddr & (pmask + VA_W'(1)));
  assign pfn   = odd ? lookup.slot.pfn_odd : lookup.slot.pfn_even;
  assign flags = odd ? lookup.slot.flags_odd : lookup.slot.flags_even;

  always_comb begin
    tlb_res = '{paddr: '0, exc_code: EXC_NONE, hit_index: lookup.index};
    if (!lookup.hit) begin
      tlb_res.exc_code  = st ? EXC_REFILL_STORE : EXC_REFILL_LOAD;
      tlb_res.hit_index = '0;
    end else if (!lookup.slot.glob && lookup.slot.asid != cfg.asid) begin
      tlb_res.exc_code = st ? EXC_REFILL_STORE : EXC_REFILL_LOAD;
    end else if (lookup.slot.spad) begin
      tlb_res.paddr = cfg.spad_base +
                      {{(VA_W-SPAD_OFF_W){1'b0}}, item.vaddr[SPAD_OFF_W-1:0]};
    end else if (!flags[FLAG_VALID]) begin
      tlb_res.exc_code = st ? EXC_INVALID_STORE : EXC_INVALID_LOAD;
    end else if (st && !flags[FLAG_DIRTY]) begin
      tlb_res.exc_code = EXC_MODIFIED;
    end else begin
      tlb_res.paddr = {pfn, {PAGE_OFF_W{1'b0}}} | (item.vaddr & pmask);
    end
  end

  always_comb begin
    use_tlb = 1'b0;
    res     = '{paddr: '0, exc_code: EXC_NONE, hit_index: '0};
    if (item.cmd == CMD_WRITE) begin
      res.hit_index = item.entry_index;
    end else if (kernel) begin
      if (seg == SEG_KSEG0 || seg == SEG_KSEG1) begin
        res.paddr = {3'b000, item.vaddr[VA_W-4:0]};
      end else if (cfg.erl && !item.vaddr[VA_W-1]) begin
        res.paddr = item.vaddr;
      end else begin
        use_tlb = 1'b1;
      end
    end else if (cfg.ksu == KSU_SUPER) begin
      use_tlb = !item.vaddr[VA_W-1] || seg == SEG_KSSEG;
    end else begin
      use_tlb = !item.vaddr[VA_W-1];
    end
    if (item.cmd == CMD_TRANSLATE && !kernel && !use_tlb) begin
      res.exc_code = st ? EXC_ADDR_STORE : EXC_ADDR_LOAD;
    end
    if (use_tlb) begin
      res = tlb_res;
    end
  end

endmodule

// ----- hw/rtl/mips_tlb_address_translator.sv -----
`timescale 1ns / 1ps
// top level of the tlb address translator
// Usage:
//   in_ch carries one transaction per request: cmd 0 translates vaddr for a
//   load (is_write 0) or a store (is_write 1); cmd 1 loads TLB slot
//   entry_index from the entry_* fields, with VPN2 in vaddr[31:13].
//   out_ch returns exactly one transaction per request, in order: paddr,
//   exc_code and hit_index.
//   cfg_ch writes the status registers (index 0 ksu, 1 exl, 2 erl, 3 asid,
//   4 scratchpad base); it is always ready and should be used while idle.
// Timing:
//   a request is held in the input register while all slots are compared in
//   parallel, then moves to the output register, from which out_ch takes the
//   result. One request per cycle is taken while out_ch accepts results.
//   A slot write is seen by the request accepted right after it.
// Reset:
//   all slots empty, registers at ksu 0, exl 0, erl 1, asid 0,
//   scratchpad base 0x7000_0000.
// Stall:
//   when out_ch is not ready the output register holds, the input register
//   fills and in_ch ready drops until the result is taken.
module mips_tlb_address_translator
  import mtlb_pkg::*;
#(
  parameter int TLB_SLOTS = TLB_SLOTS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  mtlb_in_if.sink    in_ch,
  mtlb_out_if.source out_ch,
  mtlb_cfg_if.sink   cfg_ch
);

  cfg_t     cfg_r;
  in_item_t in_r;
  logic     in_valid_r;
  result_t  out_r;
  logic     out_valid_r;
  logic     out_adv;
  logic     adv;
  lookup_t  lookup;
  result_t  res_nxt;

  assign out_adv     = !out_valid_r || out_ch.ready;
  assign adv         = in_valid_r && out_adv;
  assign in_ch.ready = !in_valid_r || out_adv;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_MODE_KSU:        cfg_r.ksu       <= cfg_ch.data[KSU_W-1:0];
        CFG_EXCEPTION_LEVEL: cfg_r.exl       <= cfg_ch.data[0];
        CFG_ERROR_LEVEL:     cfg_r.erl       <= cfg_ch.data[0];
        CFG_CURRENT_ASID:    cfg_r.asid      <= cfg_ch.data[ASID_W-1:0];
        CFG_SCRATCHPAD_BASE: cfg_r.spad_base <= cfg_ch.data[VA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_r <= '{
        cmd:              in_ch.cmd,
        vaddr:            in_ch.vaddr,
        is_write:         in_ch.is_write,
        entry_index:      in_ch.entry_index,
        entry_mask:       in_ch.entry_mask,
        entry_asid:       in_ch.entry_asid,
        entry_global:     in_ch.entry_global,
        entry_scratchpad: in_ch.entry_scratchpad,
        entry_pfn_even:   in_ch.entry_pfn_even,
        entry_pfn_odd:    in_ch.entry_pfn_odd,
        entry_flags_even: in_ch.entry_flags_even,
        entry_flags_odd:  in_ch.entry_flags_odd
      };
    end
  end

  mtlb_slots #(
    .TLB_SLOTS(TLB_SLOTS)
  ) u_slots (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (adv && in_r.cmd == CMD_WRITE),
    .item   (in_r),
    .lookup (lookup)
  );

  mtlb_xlate u_xlate (
    .cfg    (cfg_r),
    .item   (in_r),
    .lookup (lookup),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.paddr     = out_r.paddr;
  assign out_ch.exc_code  = out_r.exc_code;
  assign out_ch.hit_index = out_r.hit_index;

  // a slot write completes with no exception and a zero address
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_r.cmd == CMD_WRITE |=> out_r.exc_code == EXC_NONE && out_r.paddr == '0
  ) else $error("slot write result carries an address or exception");

  // any exception leaves the physical address at zero
  a_exc_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.exc_code != EXC_NONE |-> out_r.paddr == '0
  ) else $error("exception with non-zero physical address");

  // a transaction leaving the input register always lands in the output register
  a_adv_lands: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r
  ) else $error("transaction lost between input and output registers");

  // a tlb miss reports slot zero
  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    adv && in_r.cmd == CMD_TRANSLATE && !lookup.hit &&
    (res_nxt.exc_code == EXC_REFILL_LOAD || res_nxt.exc_code == EXC_REFILL_STORE)
    |=> out_r.hit_index == '0
  ) else $error("refill on a miss reports a non-zero slot");

endmodule
